### hw/rtl/saturating_control_integrator_macros.svh
// Assertion macros shared by the saturating control integrator RTL.
`ifndef SATURATING_CONTROL_INTEGRATOR_MACROS_SVH
`define SATURATING_CONTROL_INTEGRATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SCI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SCI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/sci_pkg.sv
// Shared constants, types and register codes for the saturating control integrator.
`timescale 1ns / 1ps
package sci_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int TS_W       = 32;
   localparam int FIELD_W    = 32;
   localparam int LIMIT_W    = 31;
   localparam int PROD_W     = DATA_WIDTH + TS_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic signed [DATA_WIDTH-1:0] data_type;

   localparam logic signed [FIELD_W-1:0] THRUST_MIN_RESET = 446300;
   localparam logic signed [FIELD_W-1:0] THRUST_MAX_RESET = 839516;
   localparam logic [LIMIT_W-1:0]        TILT_LIMIT_RESET = 51472;
   localparam logic [LIMIT_W-1:0]        YAW_LIMIT_RESET  = 65536;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IN_FLIGHT  = 3'd0,
      CSR_THRUST_MIN = 3'd1,
      CSR_THRUST_MAX = 3'd2,
      CSR_TILT_LIMIT = 3'd3,
      CSR_YAW_LIMIT  = 3'd4
   } csr_index_type;

   // Step strobes from the sequencer to every lane.
   typedef struct packed {
      logic load;
      logic mul_u;
      logic add_rate;
      logic mul_rate;
      logic add_value;
      logic clamp;
   } sci_ctrl_type;

endpackage

### hw/rtl/sci_if.sv
// Request and response channel interfaces of the saturating control integrator.
`timescale 1ns / 1ps
interface sci_req_if;
   import sci_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [TS_W-1:0]           timestamp;
   logic signed [FIELD_W-1:0] thrust_accel;
   logic signed [FIELD_W-1:0] roll_accel;
   logic signed [FIELD_W-1:0] pitch_accel;
   logic signed [FIELD_W-1:0] yaw_accel;

   modport source (output valid, timestamp, thrust_accel, roll_accel, pitch_accel,
                   yaw_accel, input ready);
   modport sink (input valid, timestamp, thrust_accel, roll_accel, pitch_accel,
                 yaw_accel, output ready);
endinterface

interface sci_rsp_if;
   import sci_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] thrust_out;
   logic signed [FIELD_W-1:0] roll_out;
   logic signed [FIELD_W-1:0] pitch_out;
   logic signed [FIELD_W-1:0] yaw_rate_out;

   modport source (output valid, thrust_out, roll_out, pitch_out, yaw_rate_out,
                   input ready);
   modport sink (input valid, thrust_out, roll_out, pitch_out, yaw_rate_out,
                 output ready);
endinterface

### hw/rtl/sci_lane.sv
// One integrator lane: shared multiplier, saturating accumulate and clamp.
`timescale 1ns / 1ps
`include "saturating_control_integrator_macros.svh"
module sci_lane (
   input  logic                              clock,
   input  logic                              reset,
   input  sci_pkg::sci_ctrl_type             ctrl,
   input  logic                              single_stage,
   input  logic                              zero_rate_on_clip,
   input  logic signed [sci_pkg::FIELD_W-1:0] accel,
   input  logic [sci_pkg::TS_W-1:0]          dt,
   input  sci_pkg::data_type                 lo,
   input  sci_pkg::data_type                 hi,
   output sci_pkg::data_type                 value
);
   import sci_pkg::*;

   localparam data_type MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam data_type MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   data_type               u_ff;
   data_type               rate_ff;
   data_type               rate_in;
   data_type               value_ff;
   data_type               value_in;
   logic [PROD_W-1:0]      prod_ff;
   logic [PROD_W-1:0]      prod_in;
   logic                   neg_ff;
   logic                   neg_in;
   data_type               operand;
   logic [DATA_WIDTH-1:0]  mag;
   logic [PROD_W-1:0]      quot;
   logic [DATA_WIDTH-1:0]  limit;
   logic [DATA_WIDTH-1:0]  qsat;
   logic signed [DATA_WIDTH:0] term;
   logic signed [DATA_WIDTH:0] sum;
   data_type               acc;
   data_type               acc_sat;
   data_type               upper;
   data_type               clipped;
   logic                   clip_hit;

   // Sign-magnitude multiply so the later shift rounds toward zero.
   always_comb begin
      operand = ctrl.mul_u ? u_ff : rate_ff;
      neg_in  = operand[DATA_WIDTH-1];
      mag     = neg_in ? DATA_WIDTH'(-operand) : DATA_WIDTH'(operand);
      prod_in = PROD_W'(mag) * PROD_W'(dt);
   end

   always_comb begin
      quot  = prod_ff >> FRAC_BITS;
      limit = (DATA_WIDTH'(1) << (DATA_WIDTH - 1)) - DATA_WIDTH'(!neg_ff);
      qsat  = (quot > PROD_W'(limit)) ? limit : quot[DATA_WIDTH-1:0];
      term  = neg_ff ? -$signed({1'b0, qsat}) : $signed({1'b0, qsat});
      acc   = (ctrl.add_rate && !single_stage) ? rate_ff : value_ff;
      sum   = $signed({acc[DATA_WIDTH-1], acc}) + term;
      if (sum[DATA_WIDTH] != sum[DATA_WIDTH-1]) begin
         acc_sat = sum[DATA_WIDTH] ? MIN_VAL : MAX_VAL;
      end else begin
         acc_sat = sum[DATA_WIDTH-1:0];
      end
   end

   // The upper bound is applied first, so an inverted band yields the lower one.
   always_comb begin
      upper    = (value_ff > hi) ? hi : value_ff;
      clipped  = (upper < lo) ? lo : upper;
      clip_hit = (clipped != value_ff);
   end

   always_comb begin
      rate_in  = rate_ff;
      value_in = value_ff;
      if (ctrl.add_rate) begin
         if (single_stage) begin
            value_in = acc_sat;
         end else begin
            rate_in = acc_sat;
         end
      end
      if (ctrl.add_value && !single_stage) begin
         value_in = acc_sat;
      end
      if (ctrl.clamp) begin
         value_in = clipped;
         if (zero_rate_on_clip && clip_hit) begin
            rate_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff  <= '0;
         value_ff <= '0;
      end else begin
         rate_ff  <= rate_in;
         value_ff <= value_in;
      end
      if (ctrl.load) begin
         u_ff <= DATA_WIDTH'(accel);
      end
      if (ctrl.mul_u || ctrl.mul_rate) begin
         prod_ff <= prod_in;
         neg_ff  <= neg_in;
      end
   end

   assign value = value_ff;

   `SCI_ASSERT_NEXT(a_lane_rate_cleared, clock, reset, ctrl.clamp && zero_rate_on_clip && clip_hit, rate_ff == '0, "clipped lane kept its rate")
   `SCI_ASSERT_NEXT(a_lane_in_band, clock, reset, ctrl.clamp && lo <= hi, value_ff <= $past(hi) && value_ff >= $past(lo), "clamped value outside band")
   `SCI_ASSERT_NOW(a_lane_single_no_rate, clock, reset, single_stage, rate_ff == '0, "single stage lane used its rate")

endmodule

### hw/rtl/sci_merge.sv
// Merging stage: gathers the lane values into one result and holds it for transfer.
`timescale 1ns / 1ps
module sci_merge (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  sci_pkg::data_type thrust_value,
   input  sci_pkg::data_type roll_value,
   input  sci_pkg::data_type pitch_value,
   input  sci_pkg::data_type yaw_rate_value,
   output logic              full,
   sci_rsp_if.source         rsp_ch
);
   import sci_pkg::*;

   logic                      valid_ff;
   logic signed [FIELD_W-1:0] thrust_ff;
   logic signed [FIELD_W-1:0] roll_ff;
   logic signed [FIELD_W-1:0] pitch_ff;
   logic signed [FIELD_W-1:0] yaw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         valid_ff <= 1'b0;
      end
      if (load) begin
         thrust_ff <= thrust_value[FIELD_W-1:0];
         roll_ff   <= roll_value[FIELD_W-1:0];
         pitch_ff  <= pitch_value[FIELD_W-1:0];
         yaw_ff    <= yaw_rate_value[FIELD_W-1:0];
      end
   end

   assign full                = valid_ff && !rsp_ch.ready;
   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.thrust_out   = thrust_ff;
   assign rsp_ch.roll_out     = roll_ff;
   assign rsp_ch.pitch_out    = pitch_ff;
   assign rsp_ch.yaw_rate_out = yaw_ff;

endmodule

### hw/rtl/saturating_control_integrator.sv
// Top level of the saturating control integrator: sequencer, registers and lanes.
`timescale 1ns / 1ps
// A request is taken only while the sequencer is idle, so a new item waits until
// the last one is through; each lane runs two multiply-accumulate
// passes through its single 32x32 multiplier, then a clamp step and a hand-off,
// which waits as long as an earlier result is still held on rsp_ch.
// The first item after reset only records its timestamp and is ready again next cycle.
// Reset is synchronous and active high; it clears the lane rates and values and the
// sequencer state, and returns the configuration registers to their default values.
`include "saturating_control_integrator_macros.svh"
module saturating_control_integrator (
   input  logic                               clock,
   input  logic                               reset,
   sci_req_if.sink                            req_ch,
   sci_rsp_if.source                          rsp_ch,
   input  logic                               csr_we,
   input  logic [sci_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sci_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import sci_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_U,
      ST_ADD_RATE,
      ST_MUL_RATE,
      ST_ADD_VALUE,
      ST_CLAMP,
      ST_EMIT
   } state_type;

   state_type                 state_ff;
   logic                      started_ff;
   logic [TS_W-1:0]           last_time_ff;
   logic [TS_W-1:0]           dt_ff;

   // Configuration registers.
   logic                      in_flight_ff;
   logic signed [FIELD_W-1:0] thrust_min_ff;
   logic signed [FIELD_W-1:0] thrust_max_ff;
   logic [LIMIT_W-1:0]        tilt_limit_ff;
   logic [LIMIT_W-1:0]        yaw_limit_ff;

   logic                      req_fire;
   logic                      merge_load;
   logic                      merge_full;
   sci_ctrl_type              ctrl;
   data_type                  thrust_lo;
   data_type                  thrust_hi;
   data_type                  tilt_hi;
   data_type                  tilt_lo;
   data_type                  yaw_hi;
   data_type                  yaw_lo;
   data_type                  thrust_value;
   data_type                  roll_value;
   data_type                  pitch_value;
   data_type                  yaw_rate_value;

   // The block takes a new request only while the sequencer is idle; a finished result
   // waits in the merging stage, and holds up intake only once the next result waits to be handed over.
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   // A result is only handed over in flight, and only when the output
   // register is free or is being emptied in this same cycle.
   assign merge_load = (state_ff == ST_EMIT) && in_flight_ff && !merge_full;

   always_comb begin
      ctrl.load      = req_fire && started_ff;
      ctrl.mul_u     = (state_ff == ST_MUL_U);
      ctrl.add_rate  = (state_ff == ST_ADD_RATE);
      ctrl.mul_rate  = (state_ff == ST_MUL_RATE);
      ctrl.add_value = (state_ff == ST_ADD_VALUE);
      ctrl.clamp     = (state_ff == ST_CLAMP);
   end

   // Clamp bands per lane. The symmetric limits are non-negative, so their
   // negation always fits.
   always_comb begin
      thrust_lo = DATA_WIDTH'(thrust_min_ff);
      thrust_hi = DATA_WIDTH'(thrust_max_ff);
      tilt_hi   = DATA_WIDTH'($signed({1'b0, tilt_limit_ff}));
      tilt_lo   = -tilt_hi;
      yaw_hi    = DATA_WIDTH'($signed({1'b0, yaw_limit_ff}));
      yaw_lo    = -yaw_hi;
   end

   // Sequencer and timestamp bookkeeping. The time step wraps modulo 2^32,
   // so a timestamp that goes backwards reads as a long forward step.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= 1'b0;
         last_time_ff <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  last_time_ff <= req_ch.timestamp;
                  started_ff   <= 1'b1;
                  if (started_ff) begin
                     state_ff <= ST_MUL_U;
                  end
               end
            end
            ST_MUL_U:     state_ff <= ST_ADD_RATE;
            ST_ADD_RATE:  state_ff <= ST_MUL_RATE;
            ST_MUL_RATE:  state_ff <= ST_ADD_VALUE;
            ST_ADD_VALUE: state_ff <= ST_CLAMP;
            ST_CLAMP:     state_ff <= ST_EMIT;
            ST_EMIT: begin
               if (!in_flight_ff || !merge_full) begin
                  state_ff <= ST_IDLE;
               end
            end
            default:      state_ff <= ST_IDLE;
         endcase
      end
      if (req_fire) begin
         dt_ff <= req_ch.timestamp - last_time_ff;
      end
   end

   // Configuration writes; indexes past the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff  <= 1'b0;
         thrust_min_ff <= THRUST_MIN_RESET;
         thrust_max_ff <= THRUST_MAX_RESET;
         tilt_limit_ff <= TILT_LIMIT_RESET;
         yaw_limit_ff  <= YAW_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IN_FLIGHT:  in_flight_ff  <= csr_wdata[0];
            CSR_THRUST_MIN: thrust_min_ff <= $signed(csr_wdata[FIELD_W-1:0]);
            CSR_THRUST_MAX: thrust_max_ff <= $signed(csr_wdata[FIELD_W-1:0]);
            CSR_TILT_LIMIT: tilt_limit_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_YAW_LIMIT:  yaw_limit_ff  <= csr_wdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Thrust lane: double integrator whose rate is dropped when the band clips it.
   sci_lane u_thrust_lane (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .single_stage      (1'b0),
      .zero_rate_on_clip (1'b1),
      .accel             (req_ch.thrust_accel),
      .dt                (dt_ff),
      .lo                (thrust_lo),
      .hi                (thrust_hi),
      .value             (thrust_value)
   );

   sci_lane u_roll_lane (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .single_stage      (1'b0),
      .zero_rate_on_clip (1'b0),
      .accel             (req_ch.roll_accel),
      .dt                (dt_ff),
      .lo                (tilt_lo),
      .hi                (tilt_hi),
      .value             (roll_value)
   );

   sci_lane u_pitch_lane (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .single_stage      (1'b0),
      .zero_rate_on_clip (1'b0),
      .accel             (req_ch.pitch_accel),
      .dt                (dt_ff),
      .lo                (tilt_lo),
      .hi                (tilt_hi),
      .value             (pitch_value)
   );

   // Yaw lane: single integrator, so only the first multiply-accumulate pass counts.
   sci_lane u_yaw_lane (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .single_stage      (1'b1),
      .zero_rate_on_clip (1'b0),
      .accel             (req_ch.yaw_accel),
      .dt                (dt_ff),
      .lo                (yaw_lo),
      .hi                (yaw_hi),
      .value             (yaw_rate_value)
   );

   sci_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .load           (merge_load),
      .thrust_value   (thrust_value),
      .roll_value     (roll_value),
      .pitch_value    (pitch_value),
      .yaw_rate_value (yaw_rate_value),
      .full           (merge_full),
      .rsp_ch         (rsp_ch)
   );

   `SCI_ASSERT_NEXT(a_first_item_only_time, clock, reset, req_fire && !started_ff, state_ff == ST_IDLE && started_ff, "first item did not just record time")
   `SCI_ASSERT_NEXT(a_dt_is_difference, clock, reset, req_fire && started_ff, dt_ff == $past(req_ch.timestamp) - $past(last_time_ff), "time step is not the timestamp difference")
   `SCI_ASSERT_NOW(a_result_from_emit, clock, reset, $rose(rsp_ch.valid), $past(state_ff == ST_EMIT) && in_flight_ff, "result appeared outside an in-flight hand-off")

endmodule
